// ===== hdl/dmg_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Depth min-max gray normalizer package
// Shared codes, constants and the job record passed from front to back.
// ============================================================================
package dmg_pkg;

    // Job queue geometry.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;

    // Quotient bits produced by the divider; larger quotients saturate.
    localparam int QUOT_BITS = 8;
    localparam int STEP_W    = 3;

    // Command codes carried in the request.
    typedef enum logic [1:0] {
        CMD_CLEAR   = 2'd0,
        CMD_MEASURE = 2'd1,
        CMD_CONVERT = 2'd2
    } cmd_t;

    // Configuration register indexes.
    localparam logic CFG_WIDE_SAMPLES = 1'b0;
    localparam logic CFG_BIG_ENDIAN   = 1'b1;

    // Value constants.
    localparam logic [7:0]  GRAY_MAX    = 8'd255;
    localparam logic [15:0] NARROW_SPAN = 16'd254;
    localparam logic [15:0] BOUND_UNSET = 16'hFFFF;

    // One convert job: either a ready gray value or a division to run.
    typedef struct packed {
        logic        direct;
        logic [7:0]  value;
        logic [23:0] dividend;
        logic [15:0] divisor;
    } job_t;

endpackage

// ===== hdl/dmg_channels.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Normalizer channels
// Valid/ready interfaces for the sample requests and the gray results.
// ============================================================================
interface dmg_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] first_byte;
    logic [7:0] second_byte;

    modport source (output valid, output command, output first_byte,
                    output second_byte, input ready);
    modport sink   (input valid, input command, input first_byte,
                    input second_byte, output ready);
endinterface

interface dmg_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] gray;

    modport source (output valid, output gray, input ready);
    modport sink   (input valid, input gray, output ready);
endinterface

// ===== hdl/dmg_front.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Normalizer front end
// Accepts requests, keeps the configuration and the depth bounds, and turns
// each convert request into a job for the divider back end.
// ============================================================================
module dmg_front
(
    input  logic          clk,
    input  logic          rst_n,
    dmg_in_if.sink        in_chan,
    input  logic          cfg_we,
    input  logic          cfg_index,
    input  logic          cfg_data,
    input  logic          fifo_full,
    output logic          job_push,
    output dmg_pkg::job_t job
);

    logic        wide_reg;
    logic        wide_next;
    logic        endian_reg;
    logic        endian_next;
    logic [15:0] low_reg;
    logic [15:0] low_next;
    logic [15:0] high_reg;
    logic [15:0] high_next;

    logic          accept;
    dmg_pkg::cmd_t cmd;
    logic [15:0]   sample;
    logic [15:0]   low_eff;
    logic [15:0]   num_base;
    logic [7:0]    narrow_base;

    // A request is taken whenever the job queue has room.
    assign in_chan.ready = !fifo_full;
    assign accept        = in_chan.valid && in_chan.ready;
    assign cmd           = dmg_pkg::cmd_t'(in_chan.command);

    // Assemble the 16-bit sample according to byte order.
    assign sample = endian_reg ? {in_chan.first_byte, in_chan.second_byte}
                               : {in_chan.second_byte, in_chan.first_byte};

    // An unset minimum counts as zero.
    assign low_eff = (low_reg == dmg_pkg::BOUND_UNSET) ? 16'd0 : low_reg;

    // Numerator before scaling by 255; the 8-bit range starts at one.
    assign narrow_base = in_chan.first_byte - 8'd1;
    assign num_base    = wide_reg ? (sample - low_eff) : {8'h00, narrow_base};

    // Build the job, settling the special cases without a division.
    always_comb
    begin
        job.direct   = 1'b0;
        job.value    = 8'd0;
        job.dividend = {num_base, 8'h00} - {8'h00, num_base};
        job.divisor  = wide_reg ? (high_reg - low_eff) : dmg_pkg::NARROW_SPAN;
        if (wide_reg)
        begin
            if (sample == 16'd0)
            begin
                job.direct = 1'b1;
                job.value  = 8'd0;
            end
            else if (high_reg <= low_eff)
            begin
                job.direct = 1'b1;
                job.value  = dmg_pkg::GRAY_MAX;
            end
            else if (sample < low_eff)
            begin
                job.direct = 1'b1;
                job.value  = 8'd0;
            end
        end
        else if (in_chan.first_byte == 8'd0)
        begin
            job.direct = 1'b1;
            job.value  = 8'd0;
        end
    end

    assign job_push = accept && (cmd == dmg_pkg::CMD_CONVERT);

    // Configuration writes and bound tracking.
    always_comb
    begin
        wide_next   = wide_reg;
        endian_next = endian_reg;
        low_next    = low_reg;
        high_next   = high_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                dmg_pkg::CFG_WIDE_SAMPLES: wide_next   = cfg_data;
                dmg_pkg::CFG_BIG_ENDIAN:   endian_next = cfg_data;
                default:                   wide_next   = wide_reg;
            endcase
        end
        if (accept)
        begin
            case (cmd)
                dmg_pkg::CMD_CLEAR:
                begin
                    low_next  = dmg_pkg::BOUND_UNSET;
                    high_next = 16'd0;
                end
                dmg_pkg::CMD_MEASURE:
                begin
                    if (wide_reg && (sample != 16'd0))
                    begin
                        if (sample < low_reg)
                        begin
                            low_next = sample;
                        end
                        if (sample > high_reg)
                        begin
                            high_next = sample;
                        end
                    end
                end
                default:
                begin
                    low_next = low_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wide_reg   <= 1'b1;
            endian_reg <= 1'b0;
            low_reg    <= dmg_pkg::BOUND_UNSET;
            high_reg   <= 16'd0;
        end
        else
        begin
            wide_reg   <= wide_next;
            endian_reg <= endian_next;
            low_reg    <= low_next;
            high_reg   <= high_next;
        end
    end

endmodule

// ===== hdl/dmg_job_fifo.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Normalizer job queue
// Small first-in first-out buffer that decouples the front end from the
// divider back end.
// ============================================================================
module dmg_job_fifo
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  dmg_pkg::job_t push_job,
    input  logic          pop,
    output dmg_pkg::job_t head_job,
    output logic          full,
    output logic          empty
);

    localparam int CNT_W = dmg_pkg::FIFO_PTR_W + 1;

    dmg_pkg::job_t                   mem_reg [dmg_pkg::FIFO_DEPTH];
    logic [dmg_pkg::FIFO_PTR_W-1:0]  wr_ptr_reg;
    logic [dmg_pkg::FIFO_PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]                count_reg;
    logic [CNT_W-1:0]                count_next;

    assign full     = (count_reg == CNT_W'(dmg_pkg::FIFO_DEPTH));
    assign empty    = (count_reg == '0);
    assign head_job = mem_reg[rd_ptr_reg];

    // Occupancy follows the push and pop strobes.
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

// ===== hdl/dmg_back.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Normalizer back end
// Takes jobs from the queue, runs an 8-step restoring divider for the
// normalized gray level and holds the result in the output register.
// ============================================================================
module dmg_back
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          fifo_empty,
    input  dmg_pkg::job_t head_job,
    output logic          pop,
    dmg_out_if.source     out_chan
);

    typedef enum logic {
        ST_IDLE,
        ST_DIVIDE
    } state_t;

    state_t                      state_reg;
    state_t                      state_next;
    logic [23:0]                 rem_reg;
    logic [23:0]                 rem_next;
    logic [22:0]                 shift_div_reg;
    logic [22:0]                 shift_div_next;
    logic [dmg_pkg::QUOT_BITS-1:0] quot_reg;
    logic [dmg_pkg::QUOT_BITS-1:0] quot_next;
    logic [dmg_pkg::STEP_W-1:0]  step_reg;
    logic [dmg_pkg::STEP_W-1:0]  step_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [7:0]                  gray_reg;
    logic [7:0]                  gray_next;

    logic                        out_free;
    logic                        trial_ok;
    logic [dmg_pkg::QUOT_BITS-1:0] quot_shifted;

    assign out_chan.valid = out_valid_reg;
    assign out_chan.gray  = gray_reg;
    assign out_free       = !out_valid_reg || out_chan.ready;

    // One restoring step: compare the remainder with the shifted divisor.
    assign trial_ok     = (rem_reg >= {1'b0, shift_div_reg});
    assign quot_shifted = {quot_reg[dmg_pkg::QUOT_BITS-2:0], trial_ok};

    always_comb
    begin
        state_next     = state_reg;
        rem_next       = rem_reg;
        shift_div_next = shift_div_reg;
        quot_next      = quot_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        gray_next      = gray_reg;
        pop            = 1'b0;

        if (out_valid_reg && out_chan.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (!fifo_empty && out_free)
                begin
                    pop = 1'b1;
                    if (head_job.direct)
                    begin
                        gray_next      = head_job.value;
                        out_valid_next = 1'b1;
                    end
                    else if (head_job.dividend >= {head_job.divisor, 8'h00})
                    begin
                        // Quotient of 256 or more saturates.
                        gray_next      = dmg_pkg::GRAY_MAX;
                        out_valid_next = 1'b1;
                    end
                    else
                    begin
                        rem_next       = head_job.dividend;
                        shift_div_next = {head_job.divisor, 7'd0};
                        quot_next      = '0;
                        step_next      = dmg_pkg::STEP_W'(dmg_pkg::QUOT_BITS - 1);
                        state_next     = ST_DIVIDE;
                    end
                end
            end
            ST_DIVIDE:
            begin
                if (trial_ok)
                begin
                    rem_next = rem_reg - {1'b0, shift_div_reg};
                end
                shift_div_next = {1'b0, shift_div_reg[22:1]};
                quot_next      = quot_shifted;
                step_next      = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    // The output register was freed when this job started.
                    gray_next      = quot_shifted;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            gray_reg      <= 8'd0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            gray_reg      <= gray_next;
        end
    end

    // Datapath registers need no reset.
    always_ff @(posedge clk)
    begin
        rem_reg       <= rem_next;
        shift_div_reg <= shift_div_next;
        quot_reg      <= quot_next;
    end

endmodule

// ===== hdl/depth_minmax_gray_normalizer_unit.sv =====
`timescale 1ns / 1ps
// Flow: each accepted convert request becomes a queue job; the back end pops it and either
// registers a gray value at once (ready or saturated) or runs the 8-step divider first.
// Throughput: requests are taken every cycle while the four-entry queue has room; the back end
// takes no new job while a division runs or while its output holds a stalled result.
// Reset: asynchronous, active low; bounds go unset, 16-bit little-endian mode, queue empty.
// ============================================================================
// Depth min-max gray normalizer
// Top level: front end, job queue and divider back end.
// ============================================================================
module depth_minmax_gray_normalizer_unit
(
    input  logic      clk,
    input  logic      rst_n,
    dmg_in_if.sink    in_chan,
    dmg_out_if.source out_chan,
    input  logic      cfg_we,
    input  logic      cfg_index,
    input  logic      cfg_data
);

    dmg_pkg::job_t push_job;
    dmg_pkg::job_t head_job;
    logic          job_push;
    logic          job_pop;
    logic          fifo_full;
    logic          fifo_empty;

    // Request intake, configuration and bounds.
    dmg_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_chan   (in_chan),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fifo_full (fifo_full),
        .job_push  (job_push),
        .job       (push_job)
    );

    // Job queue between the two halves.
    dmg_job_fifo u_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (job_push),
        .push_job (push_job),
        .pop      (job_pop),
        .head_job (head_job),
        .full     (fifo_full),
        .empty    (fifo_empty)
    );

    // Divider and result register.
    dmg_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .fifo_empty (fifo_empty),
        .head_job   (head_job),
        .pop        (job_pop),
        .out_chan   (out_chan)
    );

endmodule

// ===== hdl/dmg_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Normalizer port checker
// Watches the top-level ports and checks result ordering against requests.
// ============================================================================
module dmg_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [1:0] in_command,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] gray
);

    // Converts in flight: queue entries, one in the divider, one in the output.
    localparam int PEND_MAX = dmg_pkg::FIFO_DEPTH + 2;

    logic [3:0] pending_reg;
    logic       conv_in;
    logic       res_out;

    assign conv_in = in_valid && in_ready
                     && (dmg_pkg::cmd_t'(in_command) == dmg_pkg::CMD_CONVERT);
    assign res_out = out_valid && out_ready;

    // Count converts accepted but not yet delivered.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else if (conv_in && !res_out)
        begin
            pending_reg <= pending_reg + 1'b1;
        end
        else if (res_out && !conv_in)
        begin
            pending_reg <= pending_reg - 1'b1;
        end
    end

    // No result is shown while reset is held.
    a_quiet_in_reset: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("result valid during reset");

    // A delivered result always belongs to an earlier convert request.
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        res_out |-> (pending_reg != 4'd0))
        else $error("result without a pending convert request");

    // The design never holds more converts than its storage allows.
    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 4'(PEND_MAX))
        else $error("more converts in flight than storage holds");

    // A stalled result keeps its value.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(gray))
        else $error("stalled result changed or dropped");

endmodule

bind depth_minmax_gray_normalizer_unit dmg_checker u_dmg_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_chan.valid),
    .in_ready   (in_chan.ready),
    .in_command (in_chan.command),
    .out_valid  (out_chan.valid),
    .out_ready  (out_chan.ready),
    .gray       (out_chan.gray)
);
